// ----- rtl/modexp_pkg.sv -----
package modexp_pkg;

  localparam int WORD_BITS = 32;
  localparam int CNT_BITS  = $clog2(WORD_BITS);
  localparam int IN_BITS   = 2 * WORD_BITS;

  typedef logic [WORD_BITS-1:0] word_t;
  typedef logic [CNT_BITS-1:0]  cnt_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_REDUCE,
    ST_MULT,
    ST_WRITE
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic load;      // capture a new request
    logic step;      // one bit of the serial multiply / reduction
    logic mode_mul;  // 1: square-and-multiply pass, 0: base reduction pass
    logic out_load;  // copy running result into output register
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic in_exp_zero;  // exponent of incoming request is zero
    logic exp_one;      // only the lowest exponent bit can still be set
    logic last;         // current step is the final bit of a pass
  } status_t;

  // (a + b) mod m for a, b < m; wraps modulo 2**WORD_BITS when m is zero
  function automatic word_t mod_add(word_t a, word_t b, word_t m, logic mz);
    logic [WORD_BITS:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (!mz && (s >= {1'b0, m})) begin
      s = s - {1'b0, m};
    end
    return s[WORD_BITS-1:0];
  endfunction

endpackage

// ----- rtl/modexp_datapath.sv -----
module modexp_datapath
  import modexp_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  cmd_t               cmd,
  output status_t            status,
  input  logic [IN_BITS-1:0] in_data,
  input  logic               cfg_we,
  input  word_t              cfg_data,
  output word_t              out_data
);

  word_t modulus;
  word_t power;
  word_t result;
  word_t exp;
  word_t acc_p;
  word_t acc_r;
  word_t yshift;
  cnt_t  cnt;

  logic  mod_zero;
  word_t one_red;
  word_t add_p;
  word_t dbl_p;
  word_t dbl_r;
  word_t acc_p_next;
  word_t acc_r_next;
  logic  ybit;

  assign mod_zero = (modulus == '0);
  assign one_red  = (modulus == word_t'(1)) ? '0 : word_t'(1);
  assign ybit     = yshift[WORD_BITS-1];

  // lane P: power*power, or base reduction (adds 1 per base bit)
  assign add_p      = cmd.mode_mul ? power : one_red;
  assign dbl_p      = mod_add(acc_p, acc_p, modulus, mod_zero);
  assign acc_p_next = ybit ? mod_add(dbl_p, add_p, modulus, mod_zero) : dbl_p;

  // lane R: result*power
  assign dbl_r      = mod_add(acc_r, acc_r, modulus, mod_zero);
  assign acc_r_next = ybit ? mod_add(dbl_r, result, modulus, mod_zero) : dbl_r;

  assign status.in_exp_zero = (in_data[IN_BITS-1:WORD_BITS] == '0);
  assign status.exp_one     = (exp[WORD_BITS-1:1] == '0);
  assign status.last        = (cnt == cnt_t'(WORD_BITS - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      modulus <= word_t'(1);
    end else if (cfg_we) begin
      modulus <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      power  <= in_data[WORD_BITS-1:0];
      yshift <= in_data[WORD_BITS-1:0];
      exp    <= in_data[IN_BITS-1:WORD_BITS];
      result <= word_t'(1);
      acc_p  <= '0;
      acc_r  <= '0;
      cnt    <= '0;
    end else if (cmd.step) begin
      if (status.last) begin
        // end of pass: commit and rearm for the next exponent bit
        power  <= acc_p_next;
        yshift <= acc_p_next;
        acc_p  <= '0;
        acc_r  <= '0;
        cnt    <= '0;
        if (cmd.mode_mul) begin
          if (exp[0]) begin
            result <= acc_r_next;
          end
          exp <= exp >> 1;
        end else begin
          result <= one_red;
        end
      end else begin
        acc_p  <= acc_p_next;
        acc_r  <= acc_r_next;
        yshift <= yshift << 1;
        cnt    <= cnt + cnt_t'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data <= result;
    end
  end

  // reduced operands stay below a nonzero modulus after every pass
  a_power_reduced: assert property (@(posedge clk) disable iff (rst)
    $past(cmd.step && status.last && !mod_zero) |-> (power < modulus))
    else $error("power not reduced after pass");

  a_result_reduced: assert property (@(posedge clk) disable iff (rst)
    $past(cmd.step && status.last && !mod_zero) |-> (result < modulus))
    else $error("result not reduced after pass");

endmodule

// ----- rtl/modexp_ctrl.sv -----
module modexp_ctrl
  import modexp_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  output logic    out_valid,
  input  logic    out_ready,
  input  status_t status,
  output cmd_t    cmd
);

  state_t state;
  state_t state_next;
  logic   out_valid_next;
  logic   out_free;

  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next   = state;
    in_ready     = 1'b0;
    cmd.load     = 1'b0;
    cmd.step     = 1'b0;
    cmd.mode_mul = 1'b0;
    cmd.out_load = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = status.in_exp_zero ? ST_WRITE : ST_REDUCE;
        end
      end
      ST_REDUCE: begin
        cmd.step = 1'b1;
        if (status.last) begin
          state_next = ST_MULT;
        end
      end
      ST_MULT: begin
        cmd.step     = 1'b1;
        cmd.mode_mul = 1'b1;
        if (status.last && status.exp_one) begin
          state_next = ST_WRITE;
        end
      end
      ST_WRITE: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
    out_valid_next = (out_valid && !out_ready) || cmd.out_load;
  end

  a_mult_exp_nonzero: assert property (@(posedge clk) disable iff (rst)
    (state == ST_MULT) |-> !(status.exp_one && $past(state == ST_MULT && status.last)
                             && $past(status.exp_one)))
    else $error("multiply pass entered with exhausted exponent");

  a_out_from_write: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == ST_WRITE))
    else $error("output raised outside write state");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (cmd.out_load && out_valid) |-> out_ready)
    else $error("output overwritten before taken");

endmodule

// ----- rtl/modular_exponentiation.sv -----
// Channel   | Signals                                  | Contents (low bit up)
// ----------+------------------------------------------+--------------------------------
// s_axis    | s_axis_tvalid/tready/tdata[63:0]         | base[31:0], exponent[63:32]
// m_axis    | m_axis_tvalid/tready/tdata[31:0]         | power_result[31:0]
// cfg       | cfg_valid/cfg_ready/cfg_data[31:0]       | modulus
//
// One request at a time: load, a pass reducing base mod modulus, then one pass
// per exponent bit up to the highest set bit, then write. Each pass runs the
// bit-serial double-and-add multiplier (one bit a cycle);
// square and multiply run side by side on two lanes scanning the same power.
// Zero exponent skips all passes. Reset clears the modulus to 1.
// A finished result sits in the output register, so the next request is taken
// while the previous result is still stalled downstream.
module modular_exponentiation
  import modexp_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  // request stream
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [IN_BITS-1:0] s_axis_tdata,   // base, exponent
  // result stream
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output word_t              m_axis_tdata,   // power_result
  // modulus write port
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  word_t              cfg_data        // modulus
);

  cmd_t    cmd;
  status_t status;

  // modulus may be written at any time; only meaningful while idle
  assign cfg_ready = 1'b1;

  modexp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .status    (status),
    .cmd       (cmd)
  );

  modexp_datapath u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .status   (status),
    .in_data  (s_axis_tdata),
    .cfg_we   (cfg_valid && cfg_ready),
    .cfg_data (cfg_data),
    .out_data (m_axis_tdata)
  );

endmodule
